// ===== hw/rtl/utf8_stream_decoder_assert.svh =====
// assertion macros shared by the decoder rtl
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, held off while in reset
`define UTF8SD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8sd: same-cycle check failed");

// next-cycle implication, held off while in reset
`define UTF8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8sd: next-cycle check failed");

`endif

// ===== hw/rtl/utf8sd_pkg.sv =====
// types and constants shared by the utf-8 stream decoder
`default_nettype none

package utf8sd_pkg;

    // code point width and the fixed field widths
    localparam int CP_W   = 31;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 3;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_REPLACEMENT = 1'b0;
    localparam logic [CP_W-1:0] REPL_RESET = 31'h0000_FFFD;

    // forbidden code point ranges
    localparam logic [CP_W-1:0] SURR_LO   = 31'h0000_D800;
    localparam logic [CP_W-1:0] SURR_HI   = 31'h0000_DFFF;
    localparam logic [CP_W-1:0] NONCH_LO  = 31'h0000_FDD0;
    localparam logic [CP_W-1:0] NONCH_HI  = 31'h0000_FDEF;
    localparam logic [CP_W-1:0] NONCH_FE  = 31'h0000_FFFE;
    localparam logic [CP_W-1:0] NONCH_FF  = 31'h0000_FFFF;

    // upper bounds of each encoded length
    localparam logic [CP_W-1:0] MAX_LEN1 = 31'h0000_007F;
    localparam logic [CP_W-1:0] MAX_LEN2 = 31'h0000_07FF;
    localparam logic [CP_W-1:0] MAX_LEN3 = 31'h0000_FFFF;
    localparam logic [CP_W-1:0] MAX_LEN4 = 31'h001F_FFFF;
    localparam logic [CP_W-1:0] MAX_LEN5 = 31'h03FF_FFFF;

    // continuation byte tag in the top two bits
    localparam logic [1:0] CONT_TAG = 2'b10;

    // result queue depth
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic             was_replaced;
        logic [CNT_W-1:0] bytes_used;
        logic             last_of_run;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8sd_if.sv =====
// byte and code point stream interfaces
`default_nettype none

interface utf8sd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [2:0] bytes_left;

    modport source (output valid, output data_byte, output bytes_left, input ready);
    modport sink   (input valid, input data_byte, input bytes_left, output ready);
endinterface

interface utf8sd_code_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_point;
    logic        was_replaced;
    logic [2:0]  bytes_used;
    logic        last_of_run;

    modport source (output valid, output code_point, output was_replaced,
                    output bytes_used, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input was_replaced,
                    input bytes_used, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/utf8sd_cfg.sv =====
// apb register block holding the replacement code
`default_nettype none

module utf8sd_cfg
    import utf8sd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [CP_W-1:0]       replacement_code
);

    logic [CP_W-1:0] repl_reg;
    logic            reg_hit;
    logic            wr_en;

    // register index is the word address
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_IDX_REPLACEMENT);
    assign wr_en   = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;

    // replacement code register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg <= REPL_RESET;
        end
        else if (wr_en)
        begin
            repl_reg <= pwdata[CP_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (reg_hit)
        begin
            prdata = {{(APB_DATA_W-CP_W){1'b0}}, repl_reg};
        end
    end

    assign replacement_code = repl_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8sd_decode.sv =====
// per-byte decode: next sequence state and up to two results
`default_nettype none

module utf8sd_decode
    import utf8sd_pkg::*;
#(
    parameter int MAX_SEQ_LEN = 6,
    parameter int PART_W      = 31
)
(
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic [CNT_W-1:0]  bytes_left,
    input  wire logic [CP_W-1:0]   replacement_code,
    input  wire logic [PART_W-1:0] partial_value,
    input  wire logic [CNT_W-1:0]  expected_length,
    input  wire logic [CNT_W-1:0]  bytes_seen,
    input  wire logic [CNT_W-1:0]  skip_count,
    output logic      [PART_W-1:0] partial_next,
    output logic      [CNT_W-1:0]  expected_next,
    output logic      [CNT_W-1:0]  seen_next,
    output logic      [CNT_W-1:0]  skip_next,
    output logic      [1:0]        result_count,
    output result_t                result0,
    output result_t                result1
);

    // sequence length announced by a lead byte, one for anything else
    function automatic logic [CNT_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [CNT_W-1:0]  len;
        logic [BYTE_W-1:0] top;
        logic [BYTE_W-1:0] pat;
        len = 3'd1;
        for (int l = 2; l <= 6; l++)
        begin
            top = b >> (7 - l);
            pat = BYTE_W'(((1 << l) - 1) << 1);
            if ((l <= MAX_SEQ_LEN) && (top == pat))
            begin
                len = CNT_W'(l);
            end
        end
        return len;
    endfunction

    // shortest encoding length for a code point
    function automatic logic [CNT_W-1:0] min_len(input logic [CP_W-1:0] c);
        logic [CNT_W-1:0] len;
        if (c <= MAX_LEN1)
        begin
            len = 3'd1;
        end
        else if (c <= MAX_LEN2)
        begin
            len = 3'd2;
        end
        else if (c <= MAX_LEN3)
        begin
            len = 3'd3;
        end
        else if (c <= MAX_LEN4)
        begin
            len = 3'd4;
        end
        else if (c <= MAX_LEN5)
        begin
            len = 3'd5;
        end
        else
        begin
            len = 3'd6;
        end
        return len;
    endfunction

    logic [CNT_W-1:0]  left_c;
    logic [CNT_W-1:0]  lb_len;
    logic              lead_has;
    result_t           lead_res;
    logic [CNT_W-1:0]  lead_skip;
    logic [PART_W-1:0] lead_part;
    logic [CNT_W-1:0]  lead_exp;
    logic [CNT_W-1:0]  lead_seen;
    logic [PART_W-1:0] cont_value;
    logic [CP_W-1:0]   cont_cp;
    logic [CNT_W-1:0]  seen_inc;
    logic              cp_bad;

    // buffer count clamped to one..six
    always_comb
    begin
        left_c = bytes_left;
        if (bytes_left == 3'd0)
        begin
            left_c = 3'd1;
        end
        else if (bytes_left == 3'd7)
        begin
            left_c = 3'd6;
        end
    end

    // byte taken as a lead
    always_comb
    begin
        lb_len    = lead_len(data_byte);
        lead_has  = 1'b1;
        lead_skip = '0;
        lead_part = '0;
        lead_exp  = '0;
        lead_seen = '0;
        lead_res.code_point   = replacement_code;
        lead_res.was_replaced = 1'b1;
        lead_res.bytes_used   = 3'd1;
        lead_res.last_of_run  = 1'b1;
        if (lb_len > left_c)
        begin
            // overrun: swallow the rest of the buffer
            lead_res.bytes_used = left_c;
            lead_skip           = left_c - 3'd1;
        end
        else if (lb_len == 3'd1)
        begin
            if (!data_byte[7])
            begin
                lead_res.code_point   = {{(CP_W-7){1'b0}}, data_byte[6:0]};
                lead_res.was_replaced = 1'b0;
            end
        end
        else
        begin
            lead_has  = 1'b0;
            lead_part = PART_W'(data_byte & (8'h7F >> lb_len));
            lead_exp  = lb_len;
            lead_seen = 3'd1;
        end
    end

    // continuation value and its legality
    assign cont_value = {partial_value[PART_W-7:0], data_byte[5:0]};
    assign cont_cp    = CP_W'(cont_value);
    assign seen_inc   = bytes_seen + 3'd1;
    assign cp_bad     = (min_len(cont_cp) != expected_length) ||
                        ((cont_cp >= SURR_LO) && (cont_cp <= SURR_HI)) ||
                        ((cont_cp >= NONCH_LO) && (cont_cp <= NONCH_HI)) ||
                        (cont_cp == NONCH_FE) || (cont_cp == NONCH_FF);

    // sequence state and result selection
    always_comb
    begin
        partial_next  = partial_value;
        expected_next = expected_length;
        seen_next     = bytes_seen;
        skip_next     = skip_count;
        result_count  = 2'd0;
        result0       = lead_res;
        result1       = lead_res;
        if (skip_count != 3'd0)
        begin
            skip_next = skip_count - 3'd1;
        end
        else if (expected_length == 3'd0)
        begin
            result_count  = {1'b0, lead_has};
            partial_next  = lead_part;
            expected_next = lead_exp;
            seen_next     = lead_seen;
            skip_next     = lead_skip;
        end
        else if (data_byte[7:6] == CONT_TAG)
        begin
            partial_next = cont_value;
            seen_next    = seen_inc;
            if (seen_inc >= expected_length)
            begin
                // sequence complete
                result_count          = 2'd1;
                result0.code_point    = cp_bad ? replacement_code : cont_cp;
                result0.was_replaced  = cp_bad;
                result0.bytes_used    = expected_length;
                result0.last_of_run   = 1'b1;
                partial_next          = '0;
                expected_next         = '0;
                seen_next             = '0;
            end
        end
        else
        begin
            // bad continuation, then the byte again as a lead
            result_count          = lead_has ? 2'd2 : 2'd1;
            result0.code_point    = replacement_code;
            result0.was_replaced  = 1'b1;
            result0.bytes_used    = bytes_seen;
            result0.last_of_run   = !lead_has;
            partial_next          = lead_part;
            expected_next         = lead_exp;
            seen_next             = lead_seen;
            skip_next             = lead_skip;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8sd_out_queue.sv =====
// small result queue: up to two pushes and one pop per cycle
`default_nettype none

`include "utf8_stream_decoder_assert.svh"

module utf8sd_out_queue
    import utf8sd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] push_count,
    input  wire result_t    push0,
    input  wire result_t    push1,
    output logic [$clog2(Q_DEPTH):0] fill,
    utf8sd_code_if.source   code_out
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    result_t            entry_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;
    logic [PTR_W-1:0]   wr_ptr_b;
    logic               pop;
    result_t            head;

    assign pop      = code_out.valid && code_out.ready;
    assign wr_ptr_b = wr_ptr_reg + PTR_W'(1);

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push_count) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_b] <= push1;
        end
    end

    // head of queue onto the output beat
    assign head                  = entry_reg[rd_ptr_reg];
    assign code_out.valid        = (count_reg != '0);
    assign code_out.code_point   = head.code_point;
    assign code_out.was_replaced = head.was_replaced;
    assign code_out.bytes_used   = head.bytes_used;
    assign code_out.last_of_run  = head.last_of_run;
    assign fill                  = count_reg;

    `UTF8SD_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push_count != 2'd0, count_reg + (PTR_W+1)'(push_count) <= (PTR_W+1)'(Q_DEPTH))
    `UTF8SD_ASSERT_IMPLY(a_two_push_room, clk, rst_n, push_count == 2'd2, count_reg <= (PTR_W+1)'(Q_DEPTH - 2))
    `UTF8SD_ASSERT_NEXT(a_fill_tracks, clk, rst_n, push_count == 2'd0 && !pop, count_reg == $past(count_reg))

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_stream_decoder.sv =====
// Streaming decoder for the extended 1- to 6-byte UTF-8 form. One byte beat
// is accepted every cycle unless stalled; a byte passes the input register and
// the result queue before its first result leaves. Each byte is decoded in a
// single registered stage and its results go into a four-entry queue in front
// of the code stream. A byte gives no, one or two results; two results come
// only from a broken sequence, which always follows a byte that gave none, so
// the results never outrun the one-per-cycle code stream and the byte stream
// keeps its full rate. Only back-pressure on the code stream stalls the byte
// stream: once three or more results wait, the next byte is held in the input
// register. The replacement code is set through the APB port at byte address
// 0 and resets to U+FFFD.
`default_nettype none

`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder
    import utf8sd_pkg::*;
#(
    parameter int MAX_SEQ_LEN = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    utf8sd_byte_if.sink                byte_stream,
    utf8sd_code_if.source              code_stream,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // bits gathered by the longest sequence
    localparam int PART_W = 5 * MAX_SEQ_LEN + 1;
    localparam int FILL_W = $clog2(Q_DEPTH) + 1;

    logic [CP_W-1:0]   replacement_code;

    logic              stage_valid_reg;
    logic              stage_valid_next;
    logic [BYTE_W-1:0] stage_byte_reg;
    logic [CNT_W-1:0]  stage_left_reg;

    logic [PART_W-1:0] partial_reg;
    logic [PART_W-1:0] partial_next;
    logic [CNT_W-1:0]  exp_len_reg;
    logic [CNT_W-1:0]  exp_len_next;
    logic [CNT_W-1:0]  seen_reg;
    logic [CNT_W-1:0]  seen_next;
    logic [CNT_W-1:0]  skip_reg;
    logic [CNT_W-1:0]  skip_next;

    logic [1:0]        dec_count;
    result_t           dec_res0;
    result_t           dec_res1;
    logic [1:0]        push_count;
    logic [FILL_W-1:0] q_fill;
    logic              can_push;
    logic              stage_adv;
    logic              accept;

    // register block
    utf8sd_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .replacement_code (replacement_code)
    );

    // stage handshake: advance only with room for two results
    assign can_push          = (q_fill <= FILL_W'(Q_DEPTH - 2));
    assign stage_adv         = stage_valid_reg && can_push;
    assign byte_stream.ready = !stage_valid_reg || can_push;
    assign accept            = byte_stream.valid && byte_stream.ready;
    assign push_count        = stage_adv ? dec_count : 2'd0;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_adv)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= byte_stream.data_byte;
            stage_left_reg <= byte_stream.bytes_left;
        end
    end

    // per-byte decode
    utf8sd_decode #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN),
        .PART_W      (PART_W)
    ) u_decode (
        .data_byte        (stage_byte_reg),
        .bytes_left       (stage_left_reg),
        .replacement_code (replacement_code),
        .partial_value    (partial_reg),
        .expected_length  (exp_len_reg),
        .bytes_seen       (seen_reg),
        .skip_count       (skip_reg),
        .partial_next     (partial_next),
        .expected_next    (exp_len_next),
        .seen_next        (seen_next),
        .skip_next        (skip_next),
        .result_count     (dec_count),
        .result0          (dec_res0),
        .result1          (dec_res1)
    );

    // open sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            exp_len_reg <= '0;
            seen_reg    <= '0;
            skip_reg    <= '0;
        end
        else if (stage_adv)
        begin
            partial_reg <= partial_next;
            exp_len_reg <= exp_len_next;
            seen_reg    <= seen_next;
            skip_reg    <= skip_next;
        end
    end

    // result queue
    utf8sd_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (dec_res0),
        .push1      (dec_res1),
        .fill       (q_fill),
        .code_out   (code_stream)
    );

    `UTF8SD_ASSERT_IMPLY(a_skip_only_idle, clk, rst_n, skip_reg != 3'd0, exp_len_reg == 3'd0)
    `UTF8SD_ASSERT_IMPLY(a_seen_in_range, clk, rst_n, exp_len_reg != 3'd0, seen_reg != 3'd0 && seen_reg < exp_len_reg && exp_len_reg <= CNT_W'(MAX_SEQ_LEN))
    `UTF8SD_ASSERT_NEXT(a_skip_counts_down, clk, rst_n, stage_adv && skip_reg != 3'd0, skip_reg == $past(skip_reg) - 3'd1)
    `UTF8SD_ASSERT_IMPLY(a_skip_no_result, clk, rst_n, stage_adv && skip_reg != 3'd0, push_count == 2'd0)

endmodule

`default_nettype wire

// ===== sim/utf8sd_checker.sv =====
// checker for the utf-8 stream decoder: predicts code beats from byte beats and compares them
`timescale 1ns / 1ps

module utf8sd_checker
    import utf8sd_pkg::*;
#(
    parameter int SEQ_LIMIT = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    utf8sd_byte_if                byte_mon,
    utf8sd_code_if                code_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    output int                    errors,
    output int                    pending,
    output int                    decoded,
    output int                    checked,
    output int                    replaced
);

    localparam logic [APB_ADDR_W-1:0] REPL_ADDR = {REG_IDX_REPLACEMENT, 2'b00};

    // own copy of the decoder state and the replacement register
    logic [CP_W-1:0]  repl_code;
    logic [CP_W-1:0]  acc;
    logic [CNT_W-1:0] open_len;
    logic [CNT_W-1:0] seen;
    logic [CNT_W-1:0] skip_cnt;
    result_t          code_expect_q[$];

    function automatic result_t make_res(input logic [CP_W-1:0] cp, input logic rep,
                                         input logic [CNT_W-1:0] used, input logic last);
        result_t r;
        r.code_point   = cp;
        r.was_replaced = rep;
        r.bytes_used   = used;
        r.last_of_run  = last;
        return r;
    endfunction

    // sequence length announced by a lead byte, one for anything that cannot lead
    function automatic int seq_len_of(input logic [7:0] b);
        if (!b[7])
        begin
            return 1;
        end
        for (int n = 2; n <= SEQ_LIMIT && n <= 6; n++)
        begin
            if (int'(b >> (7 - n)) == (((1 << n) - 1) << 1))
            begin
                return n;
            end
        end
        return 1;
    endfunction

    // shortest form that can carry a code point
    function automatic int min_bytes_for(input logic [CP_W-1:0] c);
        if (c <= MAX_LEN1) return 1;
        if (c <= MAX_LEN2) return 2;
        if (c <= MAX_LEN3) return 3;
        if (c <= MAX_LEN4) return 4;
        if (c <= MAX_LEN5) return 5;
        return 6;
    endfunction

    function automatic bit is_forbidden(input logic [CP_W-1:0] c);
        return (c >= SURR_LO && c <= SURR_HI) || (c >= NONCH_LO && c <= NONCH_HI)
            || c == NONCH_FE || c == NONCH_FF;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        $display("%s", msg);
    endtask

    // treat a byte as the start of a sequence
    task automatic start_seq(input logic [7:0] b, input logic [CNT_W-1:0] left,
                             output bit made, output result_t r);
        int n;
        n = seq_len_of(b);
        made = 1'b1;
        r = '0;
        if (n > int'(left))
        begin
            // sequence runs past the buffer: one replacement, swallow the rest
            r = make_res(repl_code, 1'b1, left, 1'b1);
            skip_cnt = left - 3'd1;
        end
        else if (n == 1)
        begin
            if (b[7])
            begin
                r = make_res(repl_code, 1'b1, 3'd1, 1'b1);
            end
            else
            begin
                r = make_res({24'b0, b[6:0]}, 1'b0, 3'd1, 1'b1);
            end
        end
        else
        begin
            made = 1'b0;
            acc = CP_W'(b & (8'h7F >> n));
            open_len = n[CNT_W-1:0];
            seen = 3'd1;
        end
    endtask

    // expected code beats for one accepted byte beat
    task automatic decode_byte(input logic [7:0] b, input logic [CNT_W-1:0] raw_left);
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] taken;
        logic [CP_W-1:0]  c;
        bit               made;
        bit               bad;
        result_t          lead_res;
        left = (raw_left == 3'd0) ? 3'd1 : ((raw_left == 3'd7) ? 3'd6 : raw_left);
        if (skip_cnt != 3'd0)
        begin
            skip_cnt--;
        end
        else if (open_len == 3'd0)
        begin
            decoded++;
            start_seq(b, left, made, lead_res);
            if (made) code_expect_q.push_back(lead_res);
        end
        else if (b[7:6] == CONT_TAG)
        begin
            decoded++;
            acc = {acc[CP_W-7:0], b[5:0]};
            seen++;
            if (seen >= open_len)
            begin
                c = acc;
                bad = (min_bytes_for(c) != int'(open_len)) || is_forbidden(c);
                code_expect_q.push_back(make_res(bad ? repl_code : c, bad, open_len, 1'b1));
                open_len = '0;
                seen = '0;
                acc = '0;
            end
        end
        else
        begin
            // broken sequence: replace what was taken, then decode the byte afresh
            decoded++;
            taken = seen;
            open_len = '0;
            seen = '0;
            acc = '0;
            start_seq(b, left, made, lead_res);
            code_expect_q.push_back(make_res(repl_code, 1'b1, taken, !made));
            if (made) code_expect_q.push_back(lead_res);
        end
    endtask

    task automatic check_code_beat();
        result_t got;
        result_t want;
        got = make_res(code_mon.code_point, code_mon.was_replaced,
                       code_mon.bytes_used, code_mon.last_of_run);
        checked++;
        if (code_expect_q.size() == 0)
        begin
            note_error($sformatf("%0t: code beat with none expected: cp=%h rep=%b used=%0d last=%b",
                       $time, got.code_point, got.was_replaced, got.bytes_used,
                       got.last_of_run));
        end
        else
        begin
            want = code_expect_q.pop_front();
            if (want.was_replaced) replaced++;
            if (got !== want)
            begin
                note_error($sformatf(
                    {"%0t: code beat mismatch: expected cp=%h rep=%b used=%0d last=%b, ",
                     "got cp=%h rep=%b used=%0d last=%b"},
                    $time, want.code_point, want.was_replaced, want.bytes_used,
                    want.last_of_run, got.code_point, got.was_replaced, got.bytes_used,
                    got.last_of_run));
            end
        end
    endtask

    // watch both streams and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_code = REPL_RESET;
            acc = '0;
            open_len = '0;
            seen = '0;
            skip_cnt = '0;
            code_expect_q.delete();
            errors = 0;
            decoded = 0;
            checked = 0;
            replaced = 0;
            pending = 0;
        end
        else
        begin
            if (code_mon.valid && code_mon.ready) check_code_beat();
            if (byte_mon.valid && byte_mon.ready)
            begin
                decode_byte(byte_mon.data_byte, byte_mon.bytes_left);
            end
            if (psel && penable && pready && paddr == REPL_ADDR)
            begin
                if (pwrite)
                begin
                    repl_code = pwdata[CP_W-1:0];
                end
                else if (prdata !== APB_DATA_W'(repl_code))
                begin
                    note_error($sformatf("%0t: replacement read mismatch: expected %h, got %h",
                               $time, APB_DATA_W'(repl_code), prdata));
                end
            end
            pending = code_expect_q.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// testbench top for the utf-8 stream decoder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import utf8sd_pkg::*;

    localparam int SEQ_MAX      = 6;
    localparam int DRAIN_CYCLES = 8;
    // far above the longest quiet stretch of a correct run (gap, stall, pipeline)
    localparam int STALL_LIMIT  = 1000;
    localparam logic [APB_ADDR_W-1:0] REPL_ADDR = {REG_IDX_REPLACEMENT, 2'b00};

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   errors;
    int   pending;
    int   decoded;
    int   checked;
    int   replaced;
    int   wd_count = 0;
    int   stall_left = 0;
    int   n_settings = 1;
    bit   idle_on = 1'b1;
    logic [7:0] buf_q[$];

    utf8sd_byte_if bsi();
    utf8sd_code_if csi();

    utf8_stream_decoder #(.MAX_SEQ_LEN(SEQ_MAX)) DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (bsi),
        .code_stream (csi),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    utf8sd_checker #(.SEQ_LIMIT(SEQ_MAX)) decode_check
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_mon (bsi),
        .code_mon (csi),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .errors   (errors),
        .pending  (pending),
        .decoded  (decoded),
        .checked  (checked),
        .replaced (replaced)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // code stream back-pressure in random bursts
    initial
    begin
        csi.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
            begin
                csi.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                csi.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                csi.ready <= 1'b0;
            end
            else
            begin
                csi.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat on any port
    always @(posedge clk)
    begin
        if (!rst_n || (bsi.valid && bsi.ready) || (csi.valid && csi.ready) || (psel && penable))
        begin
            wd_count <= 0;
        end
        else if (wd_count >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top failed");
            $finish;
        end
        else
        begin
            wd_count <= wd_count + 1;
        end
    end

    // one byte beat, with an optional idle burst in front
    task automatic send_byte(input logic [7:0] b, input logic [2:0] left);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            bsi.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        bsi.valid      <= 1'b1;
        bsi.data_byte  <= b;
        bsi.bytes_left <= left;
        do @(posedge clk); while (!bsi.ready);
        @(negedge clk);
    endtask

    // send the buffer with bytes_left counted down, saturated at six
    task automatic send_buffer();
        int         rem;
        logic [2:0] rl;
        for (int i = 0; i < buf_q.size(); i++)
        begin
            rem = buf_q.size() - i;
            rl = (rem > 6) ? 3'd6 : rem[2:0];
            // out-of-range counts that the block folds back
            if (rl == 3'd1 && $urandom_range(0, 31) == 0) rl = 3'd0;
            if (rl == 3'd6 && $urandom_range(0, 31) == 0) rl = 3'd7;
            send_byte(buf_q[i], rl);
        end
        buf_q.delete();
    endtask

    task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // stop sending, let every result out, then the pipeline settle
    task automatic drain();
        bsi.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_replacement(input logic [CP_W-1:0] code);
        drain();
        apb_access(1'b1, REPL_ADDR, APB_DATA_W'(code));
        apb_access(1'b0, REPL_ADDR, '0);
        n_settings++;
    endtask

    function automatic logic [CP_W-1:0] len_floor(input int len);
        case (len)
            1:       return '0;
            2:       return MAX_LEN1 + 31'd1;
            3:       return MAX_LEN2 + 31'd1;
            4:       return MAX_LEN3 + 31'd1;
            5:       return MAX_LEN4 + 31'd1;
            default: return MAX_LEN5 + 31'd1;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] len_ceil(input int len);
        case (len)
            1:       return MAX_LEN1;
            2:       return MAX_LEN2;
            3:       return MAX_LEN3;
            4:       return MAX_LEN4;
            5:       return MAX_LEN5;
            default: return 31'h7FFF_FFFF;
        endcase
    endfunction

    // encode a code point in the given number of bytes, overlong allowed
    task automatic append_char(input logic [CP_W-1:0] cp, input int len);
        logic [7:0] lead_byte;
        if (len == 1)
        begin
            buf_q.push_back({1'b0, cp[6:0]});
        end
        else
        begin
            lead_byte = 8'(8'hFF << (8 - len)) | (8'(cp >> (6 * (len - 1))) & (8'h7F >> len));
            buf_q.push_back(lead_byte);
            for (int k = len - 2; k >= 0; k--)
            begin
                buf_q.push_back({CONT_TAG, 6'(cp >> (6 * k))});
            end
        end
    endtask

    // one character: mostly well-formed, some overlong, forbidden, cut short or noise
    task automatic append_rand_char();
        int              pick;
        int              len;
        int              drop;
        logic [CP_W-1:0] cp;
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 6);
        case ($urandom_range(0, 7))
            0:       cp = len_floor(len);
            1:       cp = len_ceil(len);
            default: cp = CP_W'($urandom_range(len_ceil(len), len_floor(len)));
        endcase
        if (pick < 60)
        begin
            append_char(cp, len);
        end
        else if (pick < 70)
        begin
            len = $urandom_range(2, 6);
            append_char(CP_W'($urandom_range(len_floor(len) - 1, 0)), len);
        end
        else if (pick < 80)
        begin
            case ($urandom_range(0, 3))
                0:       cp = CP_W'($urandom_range(SURR_HI, SURR_LO));
                1:       cp = CP_W'($urandom_range(NONCH_HI, NONCH_LO));
                2:       cp = NONCH_FE;
                default: cp = NONCH_FF;
            endcase
            append_char(cp, 3);
        end
        else if (pick < 90)
        begin
            len = $urandom_range(2, 6);
            append_char(CP_W'($urandom_range(len_ceil(len), len_floor(len))), len);
            drop = $urandom_range(1, len - 1);
            repeat (drop) void'(buf_q.pop_back());
        end
        else
        begin
            buf_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // random buffers until enough bytes have been decoded
    task automatic run_random(input int n_bytes, input bit allow_idle);
        int start;
        int cut;
        start = decoded;
        idle_on = allow_idle;
        while (decoded - start < n_bytes)
        begin
            if (allow_idle && $urandom_range(0, 15) == 0) idle_on = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 4)) append_rand_char();
            // cut the buffer short now and then so sequences overrun its end
            if ($urandom_range(0, 4) == 0)
            begin
                cut = $urandom_range(1, buf_q.size());
                while (buf_q.size() > cut) void'(buf_q.pop_back());
            end
            send_buffer();
        end
    endtask

    initial
    begin
        bsi.valid      = 1'b0;
        bsi.data_byte  = '0;
        bsi.bytes_left = 3'd1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset value of the replacement code
        apb_access(1'b0, REPL_ADDR, '0);

        // ascii extremes and invalid leads
        buf_q = '{8'h00, 8'h7F};
        send_buffer();
        buf_q = '{8'h80, 8'hFE, 8'hFF};
        send_buffer();
        // two-byte character and an overlong one
        buf_q = '{8'hC3, 8'hA9};
        send_buffer();
        buf_q = '{8'hC0, 8'h80};
        send_buffer();
        // surrogate, noncharacter and fffe
        buf_q = '{8'hED, 8'hA0, 8'h80};
        send_buffer();
        buf_q = '{8'hEF, 8'hB7, 8'h90};
        send_buffer();
        buf_q = '{8'hEF, 8'hBF, 8'hBE};
        send_buffer();
        // largest six-byte value
        buf_q = '{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
        send_buffer();
        // four-byte lead with two bytes left, then the swallowed byte
        buf_q = '{8'hF0, 8'h9F};
        send_buffer();
        // broken sequence followed by ascii gives two results
        buf_q = '{8'hE2, 8'h82, 8'h41};
        send_buffer();
        // bytes_left of zero and of seven
        send_byte(8'h41, 3'd0);
        send_byte(8'h42, 3'd7);

        run_random(400, 1'b1);
        set_replacement('0);
        run_random(500, 1'b1);
        set_replacement(31'h7FFF_FFFF);
        run_random(500, 1'b1);
        // last part without idling on either side
        set_replacement(CP_W'($urandom));
        run_random(550, 1'b0);
        drain();

        $display("decoded %0d bytes, checked %0d code beats, %0d of them replacements",
                 decoded, checked, replaced);
        $display("replacement code run through %0d settings incl. zero and all ones",
                 n_settings);
        if (errors == 0 && pending == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
